// ===== design/byte_ring_fifo_top_assert.svh =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_top_assert: assertion macros for the byte ring FIFO
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle
`define BRF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never hold
`define BRF_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== design/brf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO
// Word formats, the queue command between front and back, and the cursor
// helper functions.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int DEPTH     = 1024;
	localparam int MAX_BURST = 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int FILL_W    = $clog2(DEPTH + 1);
	localparam int CNT_W     = $clog2(MAX_BURST + 1);
	localparam int SUM_W     = FILL_W + 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// opcodes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PARAM = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       chunk_last;
		logic [6:0] request_len;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        last;
		logic [10:0] fill_count;
	} out_word_t;

	// one queued command: either a single result (with optional store write)
	// or a read burst of count bytes starting at addr
	typedef struct packed {
		logic              burst;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  count;
		logic [1:0]        status;
		logic [FILL_W-1:0] fill;
	} cmd_t;

	// queue status toward the front and back
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	// effective ring size: zero acts as one, oversize acts as DEPTH
	function automatic logic [FILL_W-1:0] cap_clamp(input logic [FILL_W-1:0] c);
		logic [FILL_W-1:0] r;
		r = c;
		if (c == '0)
			r = FILL_W'(1);
		else if (c > FILL_W'(DEPTH))
			r = FILL_W'(DEPTH);
		return r;
	endfunction

	// cursor step with wrap at the ring size
	function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] c,
		input logic [FILL_W-1:0] cap);
		logic [FILL_W-1:0] n;
		n = FILL_W'(c) + FILL_W'(1);
		return (n >= cap) ? '0 : n[ADDR_W-1:0];
	endfunction

endpackage

// ===== design/brf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_queue: command queue between front and back
// Four entries of decoded commands so that each side can stall on its own.
// ----------------------------------------------------------------------------
module brf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brf_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output brf_pkg::cmd_t  head,
	output brf_pkg::q_stat_t stat
);

	brf_pkg::cmd_t                 ent_q [brf_pkg::QDEPTH];
	logic [brf_pkg::QPTR_W-1:0]    wptr_q;
	logic [brf_pkg::QPTR_W-1:0]    rptr_q;
	logic [brf_pkg::QCNT_W-1:0]    cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wptr_q] <= push_cmd;
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head       = ent_q[rptr_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == brf_pkg::QCNT_W'(brf_pkg::QDEPTH));

endmodule

// ===== design/brf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_front: input side of the byte ring FIFO
// Accepts words, owns the cursors and fill, stages push chunks and turns
// every word into one queued command.
// ----------------------------------------------------------------------------
module brf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  brf_pkg::in_word_t            in_data,
	input  logic [brf_pkg::FILL_W-1:0]   cap,
	input  brf_pkg::q_stat_t             q_stat,
	output logic                         q_push,
	output brf_pkg::cmd_t                q_cmd
);

	typedef enum logic [1:0] {
		F_RUN  = 2'b01,
		F_WALK = 2'b10
	} fstate_t;

	fstate_t                          state_q;
	logic [brf_pkg::ADDR_W-1:0]       wcur_q, rcur_q, scur_q;
	logic [brf_pkg::FILL_W-1:0]       stored_q, staged_q;
	logic                             failed_q;
	logic [brf_pkg::CNT_W-1:0]        walk_left_q;

	logic [brf_pkg::ADDR_W-1:0]       nxt_wcur, nxt_rcur, nxt_scur, sc;
	logic [brf_pkg::FILL_W-1:0]       nxt_stored, nxt_staged, sb;
	logic                             nxt_failed, fail, start_walk;
	logic [brf_pkg::SUM_W-1:0]        sum, rsum;
	logic [brf_pkg::CNT_W-1:0]        n;
	logic                             accept;

	assign in_stall = q_stat.full || (state_q != F_RUN);
	assign accept   = in_valid && !in_stall;
	assign q_push   = accept;

	// decode one word into the next cursor state and its command
	always_comb begin
		nxt_wcur   = wcur_q;
		nxt_rcur   = rcur_q;
		nxt_scur   = scur_q;
		nxt_stored = stored_q;
		nxt_staged = staged_q;
		nxt_failed = failed_q;
		start_walk = 1'b0;
		fail       = failed_q;
		sc         = scur_q;
		sb         = staged_q;
		n          = '0;
		rsum       = '0;
		sum        = brf_pkg::SUM_W'(stored_q) + brf_pkg::SUM_W'(staged_q)
			+ brf_pkg::SUM_W'(1);
		q_cmd        = '0;
		q_cmd.status = brf_pkg::ST_OK;
		q_cmd.fill   = stored_q;
		q_cmd.wdata  = in_data.data_byte;
		case (in_data.opcode) inside
			brf_pkg::OP_PUSH: begin
				// stage the byte unless the chunk already overflowed or this byte overflows it
				if (!failed_q) begin
					if (sum > brf_pkg::SUM_W'(cap)) begin
						fail = 1'b1;
					end else begin
						q_cmd.we    = 1'b1;
						q_cmd.waddr = scur_q;
						sc          = brf_pkg::advance(scur_q, cap);
						sb          = staged_q + 1'b1;
					end
				end
				q_cmd.status = fail ? brf_pkg::ST_FULL : brf_pkg::ST_OK;
				if (in_data.chunk_last) begin
					// commit or discard the whole chunk
					if (!fail) begin
						nxt_wcur   = sc;
						nxt_stored = stored_q + sb;
						nxt_scur   = sc;
					end else begin
						nxt_scur   = wcur_q;
					end
					nxt_staged = '0;
					nxt_failed = 1'b0;
					q_cmd.fill = nxt_stored;
				end else begin
					nxt_scur   = sc;
					nxt_staged = sb;
					nxt_failed = fail;
				end
			end
			brf_pkg::OP_CLEAR: begin
				nxt_wcur   = '0;
				nxt_rcur   = '0;
				nxt_scur   = '0;
				nxt_stored = '0;
				nxt_staged = '0;
				nxt_failed = 1'b0;
				q_cmd.fill = '0;
			end
			brf_pkg::OP_POP, brf_pkg::OP_PEEK: begin
				if (in_data.request_len == '0) begin
					q_cmd.status = brf_pkg::ST_PARAM;
				end else if (stored_q == '0) begin
					q_cmd.status = brf_pkg::ST_EMPTY;
				end else begin
					// clamp to burst limit and fill
					n = (in_data.request_len > brf_pkg::CNT_W'(brf_pkg::MAX_BURST))
						? brf_pkg::CNT_W'(brf_pkg::MAX_BURST) : in_data.request_len;
					if (stored_q < brf_pkg::FILL_W'(n))
						n = stored_q[brf_pkg::CNT_W-1:0];
					q_cmd.burst = 1'b1;
					q_cmd.addr  = rcur_q;
					q_cmd.count = n;
					if (in_data.opcode == brf_pkg::OP_POP) begin
						nxt_stored = stored_q - brf_pkg::FILL_W'(n);
						q_cmd.fill = nxt_stored;
						// usual case: one wrap at most; otherwise step it out
						if ((brf_pkg::FILL_W'(rcur_q) < cap) && (brf_pkg::FILL_W'(n) <= cap)) begin
							rsum = brf_pkg::SUM_W'(rcur_q) + brf_pkg::SUM_W'(n);
							if (rsum >= brf_pkg::SUM_W'(cap))
								rsum = rsum - brf_pkg::SUM_W'(cap);
							nxt_rcur = rsum[brf_pkg::ADDR_W-1:0];
						end else begin
							start_walk = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// state update; the walk steps the read cursor one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_RUN;
			wcur_q      <= '0;
			rcur_q      <= '0;
			scur_q      <= '0;
			stored_q    <= '0;
			staged_q    <= '0;
			failed_q    <= 1'b0;
			walk_left_q <= '0;
		end else begin
			unique case (state_q)
				F_RUN: begin
					if (accept) begin
						wcur_q   <= nxt_wcur;
						rcur_q   <= nxt_rcur;
						scur_q   <= nxt_scur;
						stored_q <= nxt_stored;
						staged_q <= nxt_staged;
						failed_q <= nxt_failed;
						if (start_walk) begin
							state_q     <= F_WALK;
							walk_left_q <= n;
						end
					end
				end
				F_WALK: begin
					rcur_q      <= brf_pkg::advance(rcur_q, cap);
					walk_left_q <= walk_left_q - 1'b1;
					if (walk_left_q == brf_pkg::CNT_W'(1))
						state_q <= F_RUN;
				end
				default: state_q <= F_RUN;
			endcase
		end
	end

endmodule

// ===== design/brf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_back: output side of the byte ring FIFO
// Executes queued commands in order: store writes, single results and read
// bursts, through a read stage and an output register.
// ----------------------------------------------------------------------------
module brf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brf_pkg::cmd_t                head,
	input  brf_pkg::q_stat_t             q_stat,
	output logic                         q_pop,
	input  logic [brf_pkg::FILL_W-1:0]   cap,
	output logic                         out_valid,
	input  logic                         out_stall,
	output brf_pkg::out_word_t           out_data
);

	logic [7:0]                       store_q [brf_pkg::DEPTH];

	// burst walker
	logic                             busy_q;
	logic [brf_pkg::ADDR_W-1:0]       addr_q;
	logic [brf_pkg::CNT_W-1:0]        left_q;
	logic [brf_pkg::FILL_W-1:0]       fill_q;

	// read stage
	logic                             v_s1;
	logic [7:0]                       rd_s1;
	logic [1:0]                       status_s1;
	logic                             bv_s1, last_s1;
	logic [brf_pkg::FILL_W-1:0]       fill_s1;

	// output register
	logic                             v_s2;
	brf_pkg::out_word_t               word_s2;

	logic                             adv_s2, move_s1, issue_ok, issue, rd_en, wr_en;
	logic [brf_pkg::ADDR_W-1:0]       rd_addr;
	logic [1:0]                       iss_status;
	logic                             iss_bv, iss_last;
	logic [brf_pkg::FILL_W-1:0]       iss_fill;

	assign adv_s2   = !v_s2 || !out_stall;
	assign move_s1  = v_s1 && adv_s2;
	assign issue_ok = !v_s1 || adv_s2;
	assign issue    = issue_ok && (busy_q || q_stat.valid);
	assign q_pop    = issue_ok && !busy_q && q_stat.valid;

	// pick what enters the read stage
	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		rd_addr    = head.addr;
		iss_status = head.status;
		iss_bv     = 1'b0;
		iss_last   = 1'b1;
		iss_fill   = head.fill;
		if (busy_q) begin
			rd_en      = 1'b1;
			rd_addr    = addr_q;
			iss_status = brf_pkg::ST_OK;
			iss_bv     = 1'b1;
			iss_last   = (left_q == brf_pkg::CNT_W'(1));
			iss_fill   = fill_q;
		end else if (head.burst) begin
			rd_en      = 1'b1;
			iss_status = brf_pkg::ST_OK;
			iss_bv     = 1'b1;
			iss_last   = (head.count == brf_pkg::CNT_W'(1));
		end else begin
			wr_en      = head.we;
		end
	end

	// byte store: one access per cycle
	always_ff @(posedge clk) begin
		if (issue && wr_en)
			store_q[head.waddr] <= head.wdata;
		if (issue && rd_en)
			rd_s1 <= store_q[rd_addr];
	end

	// read stage and burst payload
	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1 <= iss_status;
			bv_s1     <= iss_bv;
			last_s1   <= iss_last;
			fill_s1   <= iss_fill;
			if (!busy_q)
				fill_q <= head.fill;
		end
		if (move_s1) begin
			word_s2.status     <= status_s1;
			word_s2.out_byte   <= bv_s1 ? rd_s1 : 8'd0;
			word_s2.byte_valid <= bv_s1;
			word_s2.last       <= last_s1;
			word_s2.fill_count <= fill_s1;
		end
	end

	// control: stage valids and burst walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			busy_q <= 1'b0;
			addr_q <= '0;
			left_q <= '0;
		end else begin
			if (issue)
				v_s1 <= 1'b1;
			else if (move_s1)
				v_s1 <= 1'b0;

			if (move_s1)
				v_s2 <= 1'b1;
			else if (v_s2 && !out_stall)
				v_s2 <= 1'b0;

			if (issue) begin
				if (busy_q) begin
					addr_q <= brf_pkg::advance(addr_q, cap);
					left_q <= left_q - 1'b1;
					if (left_q == brf_pkg::CNT_W'(1))
						busy_q <= 1'b0;
				end else if (head.burst && (head.count != brf_pkg::CNT_W'(1))) begin
					busy_q <= 1'b1;
					addr_q <= brf_pkg::advance(head.addr, cap);
					left_q <= head.count - 1'b1;
				end
			end
		end
	end

	assign out_valid = v_s2;
	assign out_data  = word_s2;

endmodule

// ===== design/byte_ring_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_top: byte FIFO on a circular store with chunked pushes
// Input words carry push, pop, peek or clear; output words carry status,
// read bytes and the fill after each operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data, output channel
//   out_valid/out_stall/out_data; a word moves when valid is high and stall
//   is low. The APB port holds capacity_in_use at address 0 (reset 1024);
//   issue a clear after changing it.
//   Push, clear and error words give one result word each. Pop and peek
//   give one word per byte returned (up to 64), the final one marked last.
//   The first result of a word passes through the command queue, the read
//   stage and the output register after the word is accepted.
//   Throughput: one push or single-result word per cycle, and one byte per
//   cycle in a burst, set by the single port of the byte store, while no
//   stall holds the flow. A pop whose read cursor is at or past the ring size,
//   or whose length exceeds it, holds in_stall as the front steps the cursor.
//   A four-word command queue between front and back absorbs output stalls;
//   in_stall rises when it is full. Results hold steady while out_stall is
//   high. Reset empties the ring; the store contents are not cleared.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_top_assert.svh"

module byte_ring_fifo_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  brf_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output brf_pkg::out_word_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [brf_pkg::FILL_W-1:0] cap_reg_q;
	logic [brf_pkg::FILL_W-1:0] cap;
	logic                       q_push, q_pop;
	brf_pkg::cmd_t              q_cmd, q_head;
	brf_pkg::q_stat_t           q_stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_reg_q <= brf_pkg::FILL_W'(brf_pkg::DEPTH);
		else if (psel && penable && pwrite && (paddr[2] == brf_pkg::REG_CAPACITY))
			cap_reg_q <= pwdata[brf_pkg::FILL_W-1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == brf_pkg::REG_CAPACITY) ? 32'(cap_reg_q) : 32'd0;
	assign cap    = brf_pkg::cap_clamp(cap_reg_q);

	brf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cap      (cap),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	brf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	brf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.cap       (cap),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// queue must never overflow or underflow
	`BRF_ASSERT_IMPL(a_no_overflow, q_push && q_stat.full, q_pop, "command queue overflow")
	`BRF_ASSERT_IMPL(a_no_underflow, q_pop, q_stat.valid, "command queue underflow")
	// a read byte is always reported with status ok
	`BRF_ASSERT_IMPL(a_byte_ok, out_valid && out_data.byte_valid,
		out_data.status == brf_pkg::ST_OK, "read byte with error status")
	// fill never exceeds the store
	`BRF_ASSERT_NEVER(a_fill_range,
		out_valid && (out_data.fill_count > brf_pkg::FILL_W'(brf_pkg::DEPTH)),
		"fill count above store depth")

endmodule
